FILE: sv/tope_pkg.sv
// Package for the tree object entry parser.
// Holds field tags, status codes, the payload structs and the default parameter values.
// No dependencies.
package tope_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 128;
  localparam int unsigned HASH_BYTES_DEF  = 32;
  localparam int unsigned NAME_CAP_DEF    = 256;
  localparam int unsigned MODE_CAP_DEF    = 16;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    FK_MODE    = 3'd0,
    FK_SPACE   = 3'd1,
    FK_NAME    = 3'd2,
    FK_TERM    = 3'd3,
    FK_HASH    = 3'd4,
    FK_IGNORED = 3'd5
  } field_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MODE_LONG = 2'd1,
    ST_NAME_LONG = 2'd2,
    ST_TRUNC     = 2'd3
  } parse_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } tope_in_t;

  typedef struct packed {
    field_kind_t   field_kind;
    logic [7:0]    byte_out;
    logic [7:0]    entry_index;
    logic [7:0]    field_position;
    logic [31:0]   entry_mode;
    logic          entry_done;
    logic          object_end;
    parse_status_t parse_status;
    logic [7:0]    entry_total;
  } tope_out_t;

endpackage

FILE: sv/tope_if.sv
// Valid/ready channel interfaces for the tree object entry parser.
// Depends on tope_pkg for the payload structs.
interface tope_in_if;
  logic              valid;
  logic              ready;
  tope_pkg::tope_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tope_out_if;
  logic               valid;
  logic               ready;
  tope_pkg::tope_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/tree_object_entry_parser_unit.sv
// Tree object entry parser: tags each byte of a tree object by field.
// Depends on tope_pkg and the channel interfaces in tope_if.sv.
//
// The input channel in_if carries one object byte per transaction together with
// a flag that marks the final byte. Each entry is an octal ASCII mode, a space,
// a name, a zero byte and HASH_BYTES raw hash bytes. The result channel out_if
// carries exactly one transaction per input byte: the field tag, the byte, the
// entry index, the offset within the field, the mode parsed so far, an
// entry-complete flag, the end-of-object flag, the sticky status and the count
// of complete entries.
// The result is registered and appears in the cycle after its input transaction
// is accepted, and one byte is taken every cycle while the receiver is not
// stalling. A new byte is accepted whenever the result register is empty or
// is being emptied in the same cycle, so a stalled receiver stalls the input
// after one held result. After reset the block waits at the start of an entry
// with no status and no entries counted; the result for the final byte returns
// it to that same state.
module tree_object_entry_parser_unit #(
  parameter int unsigned MAX_ENTRIES = tope_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned HASH_BYTES  = tope_pkg::HASH_BYTES_DEF,
  parameter int unsigned NAME_CAP    = tope_pkg::NAME_CAP_DEF,
  parameter int unsigned MODE_CAP    = tope_pkg::MODE_CAP_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tope_in_if.sink    in_if,
  tope_out_if.source out_if
);
  import tope_pkg::*;

  localparam logic [8:0] MODE_LIM  = 9'(MODE_CAP - 1);
  localparam logic [8:0] NAME_LIM  = 9'(NAME_CAP - 1);
  localparam logic [8:0] HASH_LIM  = 9'(HASH_BYTES - 1);
  localparam logic [7:0] ENTRY_LIM = 8'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    PH_MODE,
    PH_NAME,
    PH_HASH,
    PH_IGNORE
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [31:0]   accum_r, accum_nxt;
  logic          stopped_r, stopped_nxt;
  logic [7:0]    fcount_r, fcount_nxt;
  logic [7:0]    entries_r, entries_nxt;
  parse_status_t err_r, err_nxt;
  logic          out_valid_r;
  tope_out_t     out_r, res_nxt;
  logic          in_fire;
  logic [7:0]    b;
  logic          is_octal;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;
  assign b            = in_if.data.data_byte;
  assign is_octal     = (b[7:3] == 5'b00110);

  always_comb begin
    phase_nxt   = phase_r;
    accum_nxt   = accum_r;
    stopped_nxt = stopped_r;
    fcount_nxt  = fcount_r;
    entries_nxt = entries_r;
    err_nxt     = err_r;

    res_nxt.field_kind     = FK_IGNORED;
    res_nxt.byte_out       = b;
    res_nxt.entry_index    = entries_r;
    res_nxt.field_position = 8'd0;
    res_nxt.entry_mode     = 32'd0;
    res_nxt.entry_done     = 1'b0;
    res_nxt.object_end     = in_if.data.is_last;

    unique case (phase_r)
      PH_MODE: begin
        if (b == CHAR_SPACE) begin
          res_nxt.field_kind = FK_SPACE;
          res_nxt.entry_mode = accum_r;
          phase_nxt          = PH_NAME;
          fcount_nxt         = 8'd0;
        end else if ({1'b0, fcount_r} >= MODE_LIM) begin
          if (err_r == ST_OK) begin
            err_nxt = ST_MODE_LONG;
          end
          phase_nxt = PH_IGNORE;
        end else begin
          if (!stopped_r && is_octal) begin
            accum_nxt = {accum_r[28:0], b[2:0]};
          end else begin
            stopped_nxt = 1'b1;
          end
          res_nxt.field_kind     = FK_MODE;
          res_nxt.field_position = fcount_r;
          res_nxt.entry_mode     = accum_nxt;
          fcount_nxt             = fcount_r + 8'd1;
        end
      end
      PH_NAME: begin
        if (b == CHAR_NUL) begin
          res_nxt.field_kind     = FK_TERM;
          res_nxt.field_position = fcount_r;
          res_nxt.entry_mode     = accum_r;
          phase_nxt              = PH_HASH;
          fcount_nxt             = 8'd0;
        end else if ({1'b0, fcount_r} >= NAME_LIM) begin
          if (err_r == ST_OK) begin
            err_nxt = ST_NAME_LONG;
          end
          phase_nxt = PH_IGNORE;
        end else begin
          res_nxt.field_kind     = FK_NAME;
          res_nxt.field_position = fcount_r;
          res_nxt.entry_mode     = accum_r;
          fcount_nxt             = fcount_r + 8'd1;
        end
      end
      PH_HASH: begin
        res_nxt.field_kind     = FK_HASH;
        res_nxt.field_position = fcount_r;
        res_nxt.entry_mode     = accum_r;
        fcount_nxt             = fcount_r + 8'd1;
        if ({1'b0, fcount_r} >= HASH_LIM) begin
          res_nxt.entry_done = 1'b1;
          entries_nxt        = entries_r + 8'd1;
          accum_nxt          = 32'd0;
          stopped_nxt        = 1'b0;
          fcount_nxt         = 8'd0;
          phase_nxt          = (entries_nxt >= ENTRY_LIM) ? PH_IGNORE : PH_MODE;
        end
      end
      PH_IGNORE: begin
      end
      default: begin
      end
    endcase

    if (in_if.data.is_last && err_nxt == ST_OK && phase_nxt != PH_IGNORE &&
        !(phase_nxt == PH_MODE && fcount_nxt == 8'd0)) begin
      err_nxt = ST_TRUNC;
    end

    res_nxt.parse_status = err_nxt;
    res_nxt.entry_total  = entries_nxt;

    if (in_if.data.is_last) begin
      phase_nxt   = PH_MODE;
      accum_nxt   = 32'd0;
      stopped_nxt = 1'b0;
      fcount_nxt  = 8'd0;
      entries_nxt = 8'd0;
      err_nxt     = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_MODE;
      accum_r     <= 32'd0;
      stopped_r   <= 1'b0;
      fcount_r    <= 8'd0;
      entries_r   <= 8'd0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r   <= phase_nxt;
        accum_r   <= accum_nxt;
        stopped_r <= stopped_nxt;
        fcount_r  <= fcount_nxt;
        entries_r <= entries_nxt;
        err_r     <= err_nxt;
        out_r     <= res_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/tope_checker.sv
// Port-level checker for the tree object entry parser, bound to the top level.
// Depends on tope_pkg and on the top level's channel ports.
module tope_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tope_pkg::tope_out_t out_data
);
  import tope_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("A stalled result transaction changed or was dropped.");

  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("Input was ready while a result transaction was stalled.");

  a_done_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.entry_done |->
      out_data.field_kind == FK_HASH &&
      out_data.entry_total == out_data.entry_index + 8'd1)
    else $error("An entry completed on a byte that is not its last hash byte.");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.field_kind == FK_IGNORED |->
      out_data.field_position == 8'd0 && out_data.entry_mode == 32'd0 &&
      !out_data.entry_done)
    else $error("An ignored byte carried a position, a mode or a completion.");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("An accepted input transaction produced no result.");

endmodule

bind tree_object_entry_parser_unit tope_checker u_tope_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
